[sv/ira_pkg.sv]
// ----------------------------------------------------------------------------
// ira_pkg
// Shared types, constants and helpers for the integer to radix ascii block.
// ----------------------------------------------------------------------------
package ira_pkg;

    // radix register and limits
    localparam int          RADIX_BITS  = 6;
    localparam int          DIGIT_BITS  = 6;
    localparam int          CHAR_BITS   = 8;
    localparam logic [5:0]  RADIX_RESET = 6'd10;
    localparam logic [5:0]  RADIX_MIN   = 6'd2;
    localparam logic [5:0]  RADIX_MAX   = 6'd36;

    // quotient bits resolved per divider cycle
    localparam int          CHUNK_BITS  = 8;

    // character codes
    localparam logic [7:0]  CHAR_MINUS  = 8'h2D;
    localparam logic [7:0]  CHAR_ZERO   = 8'h30;
    localparam logic [7:0]  CHAR_LOWER_A = 8'h61;
    localparam logic [7:0]  CHAR_NUL    = 8'h00;
    localparam logic [5:0]  DIGIT_TEN   = 6'd10;
    localparam logic [5:0]  DIGIT_LIMIT = 6'd36;

    // classified request handed from front to back
    typedef struct packed {
        logic                    bad;
        logic                    neg;
        logic [RADIX_BITS-1:0]   radix;
    } t_job_ctl;

    // back end sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_BAD,
        ST_SIGN,
        ST_READ,
        ST_EMIT
    } t_back_state;

    // digit value to lowercase ascii
    function automatic logic [7:0] digit_char(input logic [DIGIT_BITS-1:0] d);
        logic [7:0] c;
        if (d < DIGIT_TEN) begin
            c = 8'(CHAR_ZERO + {2'b00, d});
        end else if (d < DIGIT_LIMIT) begin
            c = 8'(CHAR_LOWER_A + {2'b00, d} - {2'b00, DIGIT_TEN});
        end else begin
            c = CHAR_ZERO;
        end
        return c;
    endfunction

endpackage

[sv/ira_fifo.sv]
// ----------------------------------------------------------------------------
// ira_fifo
// Two-entry queue that decouples the classifying front from the back end.
// ----------------------------------------------------------------------------
module ira_fifo #(
    parameter int WIDTH = 40
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wptr;
    logic             r_rptr;
    logic [1:0]       r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wptr <= ~r_wptr;
            end
            if (do_pop) begin
                r_rptr <= ~r_rptr;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

[sv/ira_front.sv]
// ----------------------------------------------------------------------------
// ira_front
// Holds the radix register, accepts numbers and classifies them into
// sign, magnitude and radix check before they enter the queue.
// ----------------------------------------------------------------------------
module ira_front
    import ira_pkg::*;
#(
    parameter int WORD_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [RADIX_BITS-1:0] i_cfg_data,
    input  logic                  push,
    input  logic [WORD_BITS-1:0]  i_number,
    output logic                  full,
    output logic                  o_job_valid,
    output t_job_ctl              o_job_ctl,
    output logic [WORD_BITS-1:0]  o_job_mag,
    input  logic                  i_job_full
);

    logic [RADIX_BITS-1:0] r_radix;
    logic                  r_valid;
    t_job_ctl              r_ctl;
    logic [WORD_BITS-1:0]  r_mag;
    t_job_ctl              n_ctl;
    logic [WORD_BITS-1:0]  n_mag;
    logic                  take;
    logic                  hand_off;

    assign hand_off    = r_valid && !i_job_full;
    assign full        = r_valid && i_job_full;
    assign take        = push && !full;
    assign o_job_valid = r_valid;
    assign o_job_ctl   = r_ctl;
    assign o_job_mag   = r_mag;

    // radix register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_RESET;
        end else if (i_cfg_we) begin
            r_radix <= i_cfg_data;
        end
    end

    // classify the incoming number
    always_comb begin
        n_ctl.bad   = (r_radix < RADIX_MIN) || (r_radix > RADIX_MAX);
        n_ctl.neg   = i_number[WORD_BITS-1];
        n_ctl.radix = r_radix;
        n_mag       = n_ctl.neg ? WORD_BITS'(~i_number + 1'b1) : i_number;
    end

    // holding stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (hand_off) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_ctl <= n_ctl;
            r_mag <= n_mag;
        end
    end

endmodule

[sv/ira_back.sv]
// ----------------------------------------------------------------------------
// ira_back
// Divides the magnitude by the radix one digit at a time, keeps the digits
// in a small memory and plays them back as characters, most significant
// first, through a one-entry output register.
// ----------------------------------------------------------------------------
module ira_back
    import ira_pkg::*;
#(
    parameter int WORD_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_job_empty,
    input  t_job_ctl             i_job_ctl,
    input  logic [WORD_BITS-1:0] i_job_mag,
    output logic                 o_job_pop,
    output logic                 empty,
    input  logic                 pop,
    output logic [7:0]           o_ascii_char,
    output logic                 o_is_last,
    output logic                 o_bad_radix
);

    localparam int PAD_BITS = ((WORD_BITS + CHUNK_BITS - 1) / CHUNK_BITS) * CHUNK_BITS;
    localparam int NCHUNK   = PAD_BITS / CHUNK_BITS;
    localparam int CHUNK_W  = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int CNT_W    = $clog2(WORD_BITS + 1);
    localparam int ADDR_W   = $clog2(WORD_BITS);

    t_back_state           r_state;
    t_back_state           n_state;

    logic [PAD_BITS-1:0]   r_quo;
    logic [PAD_BITS-1:0]   n_quo;
    logic [DIGIT_BITS-1:0] r_rem;
    logic [DIGIT_BITS-1:0] n_rem;
    logic [CHUNK_W-1:0]    r_chunk;
    logic [CHUNK_W-1:0]    n_chunk;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic                  r_neg;
    logic [RADIX_BITS-1:0] r_radix;

    logic [DIGIT_BITS-1:0] r_store [WORD_BITS];
    logic [DIGIT_BITS-1:0] r_rd_data;
    logic [ADDR_W-1:0]     rd_addr;
    logic                  st_we;

    logic                  r_out_valid;
    logic [7:0]            r_out_char;
    logic                  r_out_last;
    logic                  r_out_bad;
    logic                  out_wr;
    logic [7:0]            out_char;
    logic                  out_last;
    logic                  out_bad;
    logic                  slot_free;

    logic [CHUNK_BITS-1:0] q_bits;
    logic [DIGIT_BITS-1:0] step_rem;
    logic [DIGIT_BITS:0]   trial;
    logic                  last_chunk;
    logic                  div_done;

    assign slot_free    = !r_out_valid || pop;
    assign empty        = !r_out_valid;
    assign o_ascii_char = r_out_char;
    assign o_is_last    = r_out_last;
    assign o_bad_radix  = r_out_bad;
    assign rd_addr      = ADDR_W'(r_count - 1'b1);

    // one chunk of restoring division; the remainder stays below the radix
    always_comb begin
        step_rem = r_rem;
        q_bits   = '0;
        trial    = '0;
        for (int i = 0; i < CHUNK_BITS; i++) begin
            trial = {step_rem, r_quo[PAD_BITS-1-i]};
            if (trial >= {1'b0, r_radix}) begin
                q_bits[CHUNK_BITS-1-i] = 1'b1;
                step_rem = DIGIT_BITS'(trial - {1'b0, r_radix});
            end else begin
                step_rem = trial[DIGIT_BITS-1:0];
            end
        end
    end

    assign last_chunk = (r_chunk == CHUNK_W'(NCHUNK - 1));
    assign n_quo      = (r_state == ST_IDLE) ? PAD_BITS'(i_job_mag)
                                             : PAD_BITS'({r_quo, q_bits});
    assign div_done   = last_chunk &&
                        ((n_quo == '0) || (r_count == CNT_W'(WORD_BITS - 1)));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (!i_job_empty) begin
                    n_state = i_job_ctl.bad ? ST_BAD : ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = r_neg ? ST_SIGN : ST_READ;
                end
            end
            ST_BAD: begin
                if (slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_SIGN: begin
                if (slot_free) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (slot_free) begin
                    n_state = (r_count == CNT_W'(1)) ? ST_IDLE : ST_READ;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // datapath and output controls
    always_comb begin
        o_job_pop = 1'b0;
        st_we     = 1'b0;
        out_wr    = 1'b0;
        out_char  = CHAR_NUL;
        out_last  = 1'b0;
        out_bad   = 1'b0;
        n_rem     = r_rem;
        n_chunk   = r_chunk;
        n_count   = r_count;
        case (r_state)
            ST_IDLE: begin
                o_job_pop = !i_job_empty;
                n_rem     = '0;
                n_chunk   = '0;
                n_count   = '0;
            end
            ST_DIV: begin
                if (last_chunk) begin
                    st_we   = 1'b1;
                    n_count = r_count + 1'b1;
                    n_rem   = '0;
                    n_chunk = '0;
                end else begin
                    n_rem   = step_rem;
                    n_chunk = r_chunk + 1'b1;
                end
            end
            ST_BAD: begin
                out_wr   = slot_free;
                out_char = CHAR_NUL;
                out_last = 1'b1;
                out_bad  = 1'b1;
            end
            ST_SIGN: begin
                out_wr   = slot_free;
                out_char = CHAR_MINUS;
            end
            ST_EMIT: begin
                out_wr   = slot_free;
                out_char = digit_char(r_rd_data);
                out_last = (r_count == CNT_W'(1));
                if (slot_free) begin
                    n_count = r_count - 1'b1;
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_chunk     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_chunk <= n_chunk;
            if (out_wr) begin
                r_out_valid <= 1'b1;
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // divider payload
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE || r_state == ST_DIV) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
        if (o_job_pop) begin
            r_neg   <= i_job_ctl.neg;
            r_radix <= i_job_ctl.radix;
        end
    end

    // digit store, registered read
    always_ff @(posedge i_clk) begin
        if (st_we) begin
            r_store[r_count[ADDR_W-1:0]] <= step_rem;
        end
        r_rd_data <= r_store[rd_addr];
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (out_wr) begin
            r_out_char <= out_char;
            r_out_last <= out_last;
            r_out_bad  <= out_bad;
        end
    end

endmodule

[sv/integer_to_radix_ascii.sv]
// ----------------------------------------------------------------------------
// integer_to_radix_ascii
// Signed integer to ascii text in a configurable base from 2 to 36.
// ----------------------------------------------------------------------------
// Each number pushed in comes out as its text, most significant character
// first, one character per pop: an optional leading '-', then digits 0-9 and
// lowercase a-z, with is_last on the final character. A radix outside 2..36
// gives a single NUL character with bad_radix and is_last set. The back end
// works on one number at a time: each digit comes from a shared divider that
// resolves eight quotient bits per cycle, then each character is read from
// the registered digit memory before it enters the output register, with
// the sign written ahead of the digits. A holding stage and a two-entry
// queue let up to three numbers be pushed while the back end is busy.
// The radix register resets to 10 and should be written only while the
// block is idle.
// ----------------------------------------------------------------------------
module integer_to_radix_ascii
    import ira_pkg::*;
#(
    parameter int WORD_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [RADIX_BITS-1:0] i_cfg_data,
    input  logic                  push,
    output logic                  full,
    input  logic signed [WORD_BITS-1:0] i_number,
    output logic                  empty,
    input  logic                  pop,
    output logic [7:0]            o_ascii_char,
    output logic                  o_is_last,
    output logic                  o_bad_radix
);

    localparam int CTL_BITS = $bits(t_job_ctl);

    logic                          front_valid;
    t_job_ctl                      front_ctl;
    logic [WORD_BITS-1:0]          front_mag;
    logic                          q_full;
    logic                          q_empty;
    logic                          q_pop;
    logic [CTL_BITS+WORD_BITS-1:0] q_data;
    t_job_ctl                      back_ctl;
    logic [WORD_BITS-1:0]          back_mag;

    // accept and classify
    ira_front #(
        .WORD_BITS (WORD_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .push        (push),
        .i_number    (i_number),
        .full        (full),
        .o_job_valid (front_valid),
        .o_job_ctl   (front_ctl),
        .o_job_mag   (front_mag),
        .i_job_full  (q_full)
    );

    // request queue between front and back
    ira_fifo #(
        .WIDTH (CTL_BITS + WORD_BITS)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_data  ({front_ctl, front_mag}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_data),
        .o_empty (q_empty)
    );

    assign back_ctl = t_job_ctl'(q_data[CTL_BITS+WORD_BITS-1:WORD_BITS]);
    assign back_mag = q_data[WORD_BITS-1:0];

    // divide, store and emit
    ira_back #(
        .WORD_BITS (WORD_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_empty  (q_empty),
        .i_job_ctl    (back_ctl),
        .i_job_mag    (back_mag),
        .o_job_pop    (q_pop),
        .empty        (empty),
        .pop          (pop),
        .o_ascii_char (o_ascii_char),
        .o_is_last    (o_is_last),
        .o_bad_radix  (o_bad_radix)
    );

endmodule
